// ===== hdl/srr_pkg.sv =====
package srr_pkg;

   localparam int DEPTH    = 64;
   localparam int SLOT_W   = $clog2(DEPTH);
   localparam int WLEN_W   = SLOT_W + 1;
   localparam int HANDLE_W = 16;
   localparam int SEQ_W    = 16;
   localparam int MOD_W    = 17;
   localparam int GEN_W    = 32;
   localparam int OFS_W    = MOD_W + 2;

   // item queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(DEPTH + 1);
   localparam logic [MOD_W-1:0] MOD_MAX   = MOD_W'(65536);
   localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(65536);

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUP       = 3'd1,
      ST_STALE     = 3'd2,
      ST_BEYOND    = 3'd3,
      ST_NOT_READY = 3'd4
   } status_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_READ = 1'b1
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_out_type;

endpackage

// ===== hdl/sequence_reorder_ring_unit.sv =====
// Reorder window of 64 slots for packets numbered modulo csr_wdata (clamped to
// 65..65536). An insert stores a handle at its offset from the window base and
// reports ok, duplicate, stale or beyond window; a dequeue hands out the head
// handle with its sequence number and wrap generation, or reports head not
// ready. Every word in gives exactly one word out, in order. A two-entry
// queue sits between the input and the execution unit; the execution unit
// finishes an insert or a failed dequeue in its idle state; a successful
// dequeue adds a read state for the registered read of the slot handle
// RAM. Results wait in an output register while new words are taken.
// Write the modulus only while the block is idle.
module sequence_reorder_ring_unit
   import srr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: seq_number[15:0], packet_handle[31:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: req_type[0]
   input  logic [0:0]  req_tuser,
   // rsp_tdata: out_handle[15:0], out_seq[31:16], out_generation[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // rsp_tuser: status[2:0]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_wdata
);

   queue_out_type q_out;
   logic          q_pop;

   srr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_out      (q_out),
      .q_pop      (q_pop)
   );

   srr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hdl/srr_ram.sv =====
module srr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/srr_front.sv =====
module srr_front
   import srr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,
   input  logic [0:0]    req_tuser,
   output queue_out_type q_out,
   input  logic          q_pop
);

   queue_item_type    entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   queue_item_type    new_item;
   logic              push;
   logic              pop;

   always_comb begin
      new_item.op     = op_type'(req_tuser[0]);
      new_item.seq    = req_tdata[SEQ_W-1:0];
      new_item.handle = req_tdata[SEQ_W +: HANDLE_W];
   end

   assign req_tready = (count_ff != QCNT_W'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = entry_ff[rd_ptr_ff];

endmodule

// ===== hdl/srr_back.sv =====
module srr_back
   import srr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [MOD_W-1:0] csr_wdata,
   input  queue_out_type    q_out,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser
);

   logic [MOD_W-1:0]    modulus_ff;
   logic [DEPTH-1:0]    valid_ff, valid_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [WLEN_W-1:0]   wlen_ff, wlen_in;
   logic [SEQ_W-1:0]    base_ff, base_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   back_state_type      state_ff, state_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [SEQ_W-1:0]    rsp_seq_ff, rsp_seq_in;
   logic [GEN_W-1:0]    rsp_gen_ff, rsp_gen_in;

   logic [MOD_W-1:0]    eff_mod;
   logic                seq_over;
   logic                wrap_zone;
   logic [OFS_W-1:0]    offset;
   logic                stale;
   logic                ofs_beyond;
   logic [SLOT_W-1:0]   slot_idx;
   logic                dup;
   status_type          ins_status;
   logic                deq_ok;
   logic [MOD_W-1:0]    base_inc;
   logic                base_wrap;
   logic                out_free;
   logic                is_insert;
   logic                ram_we;
   logic [HANDLE_W-1:0] ram_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_RESET;
      end else if (csr_valid) begin
         modulus_ff <= csr_wdata;
      end
   end

   always_comb begin
      eff_mod = modulus_ff;
      if (modulus_ff < MOD_MIN) begin
         eff_mod = MOD_MIN;
      end else if (modulus_ff > MOD_MAX) begin
         eff_mod = MOD_MAX;
      end
   end

   // classify an insert against the window
   always_comb begin
      seq_over   = ({1'b0, q_out.item.seq} >= eff_mod);
      wrap_zone  = ({1'b0, base_ff} > (eff_mod - MOD_W'(DEPTH)))
                   && (q_out.item.seq < SEQ_W'(DEPTH));
      offset     = OFS_W'(q_out.item.seq)
                   + (wrap_zone ? OFS_W'(eff_mod) : OFS_W'(0))
                   - OFS_W'(base_ff);
      stale      = offset[OFS_W-1];
      ofs_beyond = (offset[OFS_W-2:0] >= (OFS_W-1)'(DEPTH));
      slot_idx   = head_ff + offset[SLOT_W-1:0];
      dup        = valid_ff[slot_idx];
      if (seq_over) begin
         ins_status = ST_BEYOND;
      end else if (stale) begin
         ins_status = ST_STALE;
      end else if (ofs_beyond) begin
         ins_status = ST_BEYOND;
      end else if (dup) begin
         ins_status = ST_DUP;
      end else begin
         ins_status = ST_OK;
      end
   end

   assign deq_ok    = (wlen_ff != '0) && valid_ff[head_ff];
   assign base_inc  = {1'b0, base_ff} + 1'b1;
   assign base_wrap = (base_inc >= eff_mod);
   assign is_insert = (q_out.item.op == OP_INSERT);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      case (state_ff)
         BK_IDLE: begin
            if (q_pop && !is_insert && deq_ok) begin
               state_in = BK_READ;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_READ: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      valid_in      = valid_ff;
      head_in       = head_ff;
      wlen_in       = wlen_ff;
      base_in       = base_ff;
      gen_in        = gen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_gen_in    = rsp_gen_ff;
      case (state_ff)
         BK_IDLE: begin
            q_pop = q_out.valid && out_free;
            if (q_pop) begin
               rsp_handle_in = '0;
               rsp_seq_in    = '0;
               rsp_gen_in    = '0;
               if (is_insert) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ins_status;
                  if (ins_status == ST_OK) begin
                     ram_we             = 1'b1;
                     valid_in[slot_idx] = 1'b1;
                     if ({1'b0, wlen_ff} < offset[WLEN_W:0] + 1'b1) begin
                        wlen_in = WLEN_W'(offset[WLEN_W-1:0] + 1'b1);
                     end
                  end
               end else if (deq_ok) begin
                  // handle comes out of the RAM next cycle
                  rsp_valid_in      = 1'b0;
                  rsp_status_in     = ST_OK;
                  rsp_seq_in        = base_ff;
                  valid_in[head_ff] = 1'b0;
                  head_in           = head_ff + 1'b1;
                  wlen_in           = wlen_ff - 1'b1;
                  if (base_wrap) begin
                     base_in    = '0;
                     gen_in     = gen_ff + 1'b1;
                     rsp_gen_in = gen_ff + 1'b1;
                  end else begin
                     base_in    = base_inc[SEQ_W-1:0];
                     rsp_gen_in = gen_ff;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOT_READY;
               end
            end
         end
         BK_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_handle_in = ram_rdata;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         head_ff      <= '0;
         wlen_ff      <= '0;
         base_ff      <= '0;
         gen_ff       <= '0;
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         head_ff      <= head_in;
         wlen_ff      <= wlen_in;
         base_ff      <= base_in;
         gen_ff       <= gen_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_gen_ff    <= rsp_gen_in;
   end

   srr_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_idx),
      .wdata (q_out.item.handle),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_gen_ff, rsp_seq_ff, rsp_handle_ff};

endmodule
